// File: hdl/tslf_pkg.sv
// ============================================================================
// tslf_pkg
// Shared types and constants of the text stream line filter.
// ============================================================================
`timescale 1ns / 1ps

package tslf_pkg;

    // Default number of decimal places in a line number.
    localparam int NUMBER_DIGITS_DEF = 6;

    // Entries in the queue between the classifier and the expander.
    localparam int QUEUE_DEPTH = 2;

    // Longest printed form of one byte, excluding the line number ("M-^X").
    localparam int BODY_MAX = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NUMBER_ALL_LINES     = 3'd0,
        CFG_NUMBER_NONBLANK_ONLY = 3'd1,
        CFG_SQUEEZE_BLANK_RUNS   = 3'd2,
        CFG_MARK_LINE_ENDS       = 3'd3,
        CFG_MARK_TABS            = 3'd4,
        CFG_SHOW_NONPRINTING     = 3'd5
    } cfg_index_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [6:0] CH_DEL7   = 7'h7F;

    typedef struct packed {
        logic number_all_lines;
        logic number_nonblank_only;
        logic squeeze_blank_runs;
        logic mark_line_ends;
        logic mark_tabs;
        logic show_nonprinting;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_of_file;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // Classified byte: optional number prefix plus 1..4 printed characters.
    typedef struct packed {
        logic                     has_num;
        logic [1:0]               len_m1;
        logic [BODY_MAX-1:0][7:0] chars;
    } body_t;

endpackage

// File: hdl/tslf_front.sv
// ============================================================================
// tslf_front
// Classifier: tracks line state, decides numbering and the printed form.
// ============================================================================
`timescale 1ns / 1ps

module tslf_front #(
    parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tslf_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tslf_pkg::in_item_t           in_item,
    input  logic                         queue_full,
    output logic                         push,
    output tslf_pkg::body_t              push_body,
    output logic [4*NUMBER_DIGITS-1:0]   push_bcd
);
    import tslf_pkg::*;

    localparam int BCD_W = 4 * NUMBER_DIGITS;

    logic [7:0]       prev_reg,  prev_next;
    logic [1:0]       run_reg,   run_next;
    logic [BCD_W-1:0] bcd_reg,   bcd_next;

    logic [7:0]       c;
    logic             is_nl;
    logic             is_tab;
    logic [7:0]       prev_cur;
    logic [1:0]       run_cur;
    logic [BCD_W-1:0] bcd_cur;
    logic             num_first;
    logic             num_line;
    logic             has_num;
    logic             skip;
    logic             accept;
    logic [6:0]       low;
    logic [1:0]       tail_len_m1;
    logic [1:0][7:0]  tail;
    body_t            body;

    // Saturating BCD increment.
    function automatic logic [BCD_W-1:0] bcd_bump(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        logic             all_nines;
        logic [3:0]       d;
        r         = v;
        carry     = 1'b1;
        all_nines = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (v[4*i +: 4] != 4'd9)
            begin
                all_nines = 1'b0;
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            d = v[4*i +: 4];
            if (carry && !all_nines)
            begin
                if (d == 4'd9)
                begin
                    r[4*i +: 4] = 4'd0;
                end
                else
                begin
                    r[4*i +: 4] = d + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    assign c        = in_item.in_byte;
    assign is_nl    = (c == CH_NL);
    assign is_tab   = (c == CH_TAB);
    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;

    // File start restores the reset state before this byte is handled.
    assign prev_cur = in_item.first_of_file ? CH_SPACE : prev_reg;
    assign run_cur  = in_item.first_of_file ? 2'd0 : run_reg;
    assign bcd_cur  = in_item.first_of_file ? BCD_W'(1) : bcd_reg;

    always_comb
    begin
        if (is_nl)
        begin
            run_next = (run_cur == 2'd3) ? 2'd3 : run_cur + 2'd1;
        end
        else
        begin
            run_next = 2'd0;
        end
    end

    assign skip = cfg.squeeze_blank_runs && (run_next == 2'd3);

    assign num_first = in_item.first_of_file &&
                       ((cfg.number_all_lines && !cfg.number_nonblank_only) ||
                        (cfg.number_nonblank_only && !is_nl));
    assign num_line  = !skip && (prev_cur == CH_NL) &&
                       (cfg.number_nonblank_only ? (run_next <= 2'd1)
                                                 : cfg.number_all_lines);
    assign has_num   = num_first || num_line;

    assign prev_next = c;
    assign bcd_next  = has_num ? bcd_bump(bcd_cur) : bcd_cur;

    // Caret notation of the low seven bits.
    assign low = c[6:0];
    always_comb
    begin
        tail = '0;
        if (low == CH_DEL7)
        begin
            tail_len_m1 = 2'd1;
            tail[0]     = CH_CARET;
            tail[1]     = CH_QMARK;
        end
        else if (low >= 7'h20)
        begin
            tail_len_m1 = 2'd0;
            tail[0]     = {1'b0, low};
        end
        else if (!c[7] && (is_tab || is_nl))
        begin
            tail_len_m1 = 2'd0;
            tail[0]     = c;
        end
        else
        begin
            tail_len_m1 = 2'd1;
            tail[0]     = CH_CARET;
            tail[1]     = {1'b0, low} + 8'h40;
        end
    end

    always_comb
    begin
        body         = '0;
        body.has_num = has_num;
        if (is_nl && cfg.mark_line_ends)
        begin
            body.len_m1   = 2'd1;
            body.chars[0] = CH_DOLLAR;
            body.chars[1] = CH_NL;
        end
        else if (is_tab && cfg.mark_tabs)
        begin
            body.len_m1   = 2'd1;
            body.chars[0] = CH_CARET;
            body.chars[1] = CH_I;
        end
        else if (!cfg.show_nonprinting)
        begin
            body.len_m1   = 2'd0;
            body.chars[0] = c;
        end
        else if (c[7])
        begin
            body.len_m1   = tail_len_m1 + 2'd2;
            body.chars[0] = CH_M;
            body.chars[1] = CH_DASH;
            body.chars[2] = tail[0];
            body.chars[3] = tail[1];
        end
        else
        begin
            body.len_m1   = tail_len_m1;
            body.chars[0] = tail[0];
            body.chars[1] = tail[1];
        end
    end

    // A squeezed newline leaves nothing to print.
    assign push      = accept && !skip;
    assign push_body = body;
    assign push_bcd  = bcd_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= CH_SPACE;
            run_reg  <= 2'd0;
            bcd_reg  <= BCD_W'(1);
        end
        else if (accept)
        begin
            prev_reg <= prev_next;
            run_reg  <= run_next;
            bcd_reg  <= bcd_next;
        end
    end

endmodule

// File: hdl/tslf_queue.sv
// ============================================================================
// tslf_queue
// Small FIFO between the classifier and the expander.
// ============================================================================
`timescale 1ns / 1ps

module tslf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);
    import tslf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/tslf_back.sv
// ============================================================================
// tslf_back
// Expander: spells out one queued entry a character per cycle unless stalled.
// ============================================================================
`timescale 1ns / 1ps

module tslf_back #(
    parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       entry_valid,
    input  tslf_pkg::body_t            entry_body,
    input  logic [4*NUMBER_DIGITS-1:0] entry_bcd,
    output logic                       entry_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tslf_pkg::out_item_t        out_item
);
    import tslf_pkg::*;

    localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    typedef enum logic [2:0] {
        PH_DIGIT = 3'b001,
        PH_TAB   = 3'b010,
        PH_BODY  = 3'b100
    } phase_t;

    phase_t     phase_reg,     phase_next;
    logic [DIG_W-1:0] digit_idx_reg, digit_idx_next;
    logic [1:0] body_idx_reg,  body_idx_next;
    logic       started_reg,   started_next;
    logic       in_entry_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    phase_t     cur_phase;
    logic [DIG_W-1:0] cur_digit_idx;
    logic [1:0] cur_body_idx;
    logic       cur_started;
    logic [3:0] digit;
    logic [7:0] char_byte;
    logic       char_last;
    logic       advance;

    assign cur_phase     = in_entry_reg ? phase_reg
                                        : (entry_body.has_num ? PH_DIGIT : PH_BODY);
    assign cur_digit_idx = in_entry_reg ? digit_idx_reg : DIG_W'(NUMBER_DIGITS - 1);
    assign cur_body_idx  = in_entry_reg ? body_idx_reg : 2'd0;
    assign cur_started   = in_entry_reg && started_reg;
    assign digit         = entry_bcd[{cur_digit_idx, 2'b00} +: 4];

    always_comb
    begin
        char_byte      = CH_SPACE;
        char_last      = 1'b0;
        phase_next     = cur_phase;
        digit_idx_next = cur_digit_idx;
        body_idx_next  = cur_body_idx;
        started_next   = cur_started;
        case (cur_phase)
            PH_DIGIT:
            begin
                // Leading zeros print as spaces; the units digit always prints.
                started_next   = cur_started || (digit != 4'd0) || (cur_digit_idx == '0);
                char_byte      = started_next ? CH_ZERO + {4'h0, digit} : CH_SPACE;
                digit_idx_next = cur_digit_idx - 1'b1;
                if (cur_digit_idx == '0)
                begin
                    phase_next = PH_TAB;
                end
            end
            PH_TAB:
            begin
                char_byte     = CH_TAB;
                phase_next    = PH_BODY;
                body_idx_next = 2'd0;
            end
            PH_BODY:
            begin
                char_byte     = entry_body.chars[cur_body_idx];
                char_last     = (cur_body_idx == entry_body.len_m1);
                body_idx_next = cur_body_idx + 2'd1;
            end
            default:
            begin
                char_byte = CH_SPACE;
            end
        endcase
    end

    assign advance   = entry_valid && (!out_valid_reg || out_ready);
    assign entry_pop = advance && char_last;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            in_entry_reg  <= 1'b0;
            phase_reg     <= PH_BODY;
            digit_idx_reg <= '0;
            body_idx_reg  <= 2'd0;
            started_reg   <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            in_entry_reg  <= !char_last;
            phase_reg     <= phase_next;
            digit_idx_reg <= digit_idx_next;
            body_idx_reg  <= body_idx_next;
            started_reg   <= started_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.out_byte    <= char_byte;
            out_item_reg.last_of_run <= char_last;
        end
    end

endmodule

// File: hdl/text_stream_line_filter.sv
// ============================================================================
// text_stream_line_filter
// Cat-style text filter. Takes one file byte per request and returns the
// characters a cat-style filter prints for it: an optional right-justified
// line number of NUMBER_DIGITS places plus a tab, then the byte itself or its
// visible form ($ before newline, ^I for tab, ^X / ^? / M- notation). A
// request with first_of_file set restarts line state. The front end takes one
// byte per cycle while its two-entry queue has room; the back end emits one
// character per cycle while the receiver accepts them; a byte prints 1 to
// NUMBER_DIGITS + 5 characters. A squeezed newline prints nothing. Sustained
// rate is one byte per cycle when each byte prints one character and the
// receiver does not stall; the single-character output register sets the
// rate otherwise. last_of_run marks the final character for a byte.
// Configuration writes are taken every cycle and should be made while idle.
// ============================================================================
`timescale 1ns / 1ps

module text_stream_line_filter #(
    parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tslf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tslf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input byte requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tslf_pkg::in_item_t                  in_item,
    // Printed characters
    output logic                                out_valid,
    input  logic                                out_ready,
    output tslf_pkg::out_item_t                 out_item
);
    import tslf_pkg::*;

    localparam int BCD_W   = 4 * NUMBER_DIGITS;
    localparam int ENTRY_W = $bits(body_t) + BCD_W;

    // Mode bits; only bit 0 of the write data counts.
    cfg_t cfg_reg;

    // Classifier to queue
    logic             push;
    body_t            push_body;
    logic [BCD_W-1:0] push_bcd;
    logic             queue_full;

    // Queue to expander
    logic               head_valid;
    logic [ENTRY_W-1:0] head_data;
    logic               head_pop;
    body_t              head_body;
    logic [BCD_W-1:0]   head_bcd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUMBER_ALL_LINES:     cfg_reg.number_all_lines     <= cfg_data[0];
                CFG_NUMBER_NONBLANK_ONLY: cfg_reg.number_nonblank_only <= cfg_data[0];
                CFG_SQUEEZE_BLANK_RUNS:   cfg_reg.squeeze_blank_runs   <= cfg_data[0];
                CFG_MARK_LINE_ENDS:       cfg_reg.mark_line_ends       <= cfg_data[0];
                CFG_MARK_TABS:            cfg_reg.mark_tabs            <= cfg_data[0];
                CFG_SHOW_NONPRINTING:     cfg_reg.show_nonprinting     <= cfg_data[0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: line state, numbering decision, printed form of the byte.
    tslf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .queue_full (queue_full),
        .push       (push),
        .push_body  (push_body),
        .push_bcd   (push_bcd)
    );

    // Decouples classification from character expansion.
    tslf_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_body, push_bcd}),
        .full      (queue_full),
        .pop       (head_pop),
        .not_empty (head_valid),
        .head_data (head_data)
    );

    assign head_body = head_data[ENTRY_W-1:BCD_W];
    assign head_bcd  = head_data[BCD_W-1:0];

    // Back end: one printed character per cycle into the output register unless stalled.
    tslf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (head_valid),
        .entry_body  (head_body),
        .entry_bcd   (head_bcd),
        .entry_pop   (head_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

// File: tb/text_stream_line_filter_checker.sv
// ============================================================================
// text_stream_line_filter_checker
// Watches the config, byte and character channels of the line filter, keeps
// its own copy of the filter state, predicts the characters printed for each
// accepted byte request and compares them in order with what the block emits.
// ============================================================================
`timescale 1ns / 1ps

module text_stream_line_filter_checker #(
    parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tslf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tslf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  tslf_pkg::in_item_t               in_item,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  tslf_pkg::out_item_t              out_item,
    output int                               mismatches,
    output int                               chars_pending
);
    import tslf_pkg::*;

    localparam int         REPORT_MAX  = 10;
    localparam int         BCD_W       = 4 * NUMBER_DIGITS;
    localparam logic [7:0] HIGH_BIT    = 8'h80;
    localparam logic [7:0] CARET_SHIFT = 8'h40;
    localparam logic [7:0] CH_DEL      = {1'b0, CH_DEL7};

    cfg_t                       mode         = '0;
    logic [7:0]                 last_byte    = CH_SPACE;
    logic [1:0]                 newline_seen = '0;
    logic [BCD_W-1:0]           line_bcd     = BCD_W'(1);
    out_item_t                  printed_q[$];
    int                         fail_tally   = 0;
    int                         pending      = 0;

    assign mismatches    = fail_tally;
    assign chars_pending = pending;

    function automatic void push_char(logic [7:0] ch);
        out_item_t e;
        e.out_byte    = ch;
        e.last_of_run = 1'b0;
        printed_q.push_back(e);
    endfunction

    // Saturating BCD increment: all nines holds.
    function automatic void bump_line_number();
        bit         nines;
        logic [3:0] d;
        nines = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
            if (line_bcd[4*i +: 4] != 4'd9)
                nines = 1'b0;
        if (nines)
            return;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            d = line_bcd[4*i +: 4] + 4'd1;
            if (d <= 4'd9)
            begin
                line_bcd[4*i +: 4] = d;
                break;
            end
            line_bcd[4*i +: 4] = 4'd0;
        end
    endfunction

    // Right-justified number, leading zeros as spaces, then a tab.
    function automatic void emit_line_number();
        bit         started;
        logic [3:0] d;
        started = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            d = line_bcd[4*i +: 4];
            if (d > 4'd9)
                d = 4'd9;
            if (d != 4'd0 || started || i == 0)
            begin
                started = 1'b1;
                push_char(CH_ZERO + 8'(d));
            end
            else
                push_char(CH_SPACE);
        end
        push_char(CH_TAB);
        bump_line_number();
    endfunction

    function automatic void predict_printed(in_item_t req);
        logic [7:0] c;
        bit         squeezed;
        bit         done;
        int         old_size;
        out_item_t  e;
        c        = req.in_byte;
        old_size = printed_q.size();

        if (req.first_of_file)
        begin
            last_byte    = CH_SPACE;
            newline_seen = '0;
            line_bcd     = BCD_W'(1);
            if (mode.number_all_lines && !mode.number_nonblank_only)
                emit_line_number();
            if (mode.number_nonblank_only && c != CH_NL)
                emit_line_number();
        end

        if (c == CH_NL)
        begin
            if (newline_seen < 2'd3)
                newline_seen++;
        end
        else
            newline_seen = '0;
        squeezed = mode.squeeze_blank_runs && newline_seen > 2'd2;

        if (!squeezed && last_byte == CH_NL)
        begin
            if (mode.number_nonblank_only)
            begin
                if (newline_seen <= 2'd1)
                    emit_line_number();
            end
            else if (mode.number_all_lines)
                emit_line_number();
        end
        last_byte = c;

        done = squeezed;
        if (c == CH_NL && mode.mark_line_ends && !done)
        begin
            push_char(CH_DOLLAR);
            push_char(c);
            done = 1'b1;
        end
        if (c == CH_TAB && mode.mark_tabs)
        begin
            push_char(CH_CARET);
            push_char(CH_I);
            done = 1'b1;
        end
        if (!done)
        begin
            if (!mode.show_nonprinting)
                push_char(c);
            else if (c >= CH_SPACE)
            begin
                if (c < CH_DEL)
                    push_char(c);
                else if (c == CH_DEL)
                begin
                    push_char(CH_CARET);
                    push_char(CH_QMARK);
                end
                else
                begin
                    push_char(CH_M);
                    push_char(CH_DASH);
                    if (c >= HIGH_BIT + CH_SPACE)
                    begin
                        if (c < HIGH_BIT + CH_DEL)
                            push_char(c - HIGH_BIT);
                        else
                        begin
                            push_char(CH_CARET);
                            push_char(CH_QMARK);
                        end
                    end
                    else
                    begin
                        push_char(CH_CARET);
                        push_char(c - HIGH_BIT + CARET_SHIFT);
                    end
                end
            end
            else if (c == CH_TAB || c == CH_NL)
                push_char(c);
            else
            begin
                push_char(CH_CARET);
                push_char(c + CARET_SHIFT);
            end
        end

        if (printed_q.size() > old_size)
        begin
            e             = printed_q.pop_back();
            e.last_of_run = 1'b1;
            printed_q.push_back(e);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            mode         = '0;
            last_byte    = CH_SPACE;
            newline_seen = '0;
            line_bcd     = BCD_W'(1);
            printed_q.delete();
        end
        else
        begin
            // Results leave before this edge's request is predicted.
            if (out_valid && out_ready)
            begin
                if (printed_q.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= REPORT_MAX)
                        $display("%0t: unexpected char out_byte=%h last_of_run=%b",
                                 $realtime, out_item.out_byte, out_item.last_of_run);
                end
                else
                begin
                    want = printed_q.pop_front();
                    if (want.out_byte != out_item.out_byte ||
                        want.last_of_run != out_item.last_of_run)
                    begin
                        fail_tally++;
                        if (fail_tally <= REPORT_MAX)
                            $display("%0t: out_byte exp %h got %h, last_of_run exp %b got %b",
                                     $realtime, want.out_byte, out_item.out_byte,
                                     want.last_of_run, out_item.last_of_run);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_NUMBER_ALL_LINES:     mode.number_all_lines     = cfg_data[0];
                    CFG_NUMBER_NONBLANK_ONLY: mode.number_nonblank_only = cfg_data[0];
                    CFG_SQUEEZE_BLANK_RUNS:   mode.squeeze_blank_runs   = cfg_data[0];
                    CFG_MARK_LINE_ENDS:       mode.mark_line_ends       = cfg_data[0];
                    CFG_MARK_TABS:            mode.mark_tabs            = cfg_data[0];
                    CFG_SHOW_NONPRINTING:     mode.show_nonprinting     = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_printed(in_item);
        end
        pending = printed_q.size();
    end

endmodule

// File: tb/tb_text_stream_line_filter.sv
// ============================================================================
// tb_text_stream_line_filter
// Drives the line filter through a directed opening and a series of random
// phases under different mode settings, with bursty byte requests and a
// stalling character receiver. The checker beside the block does all
// prediction; this module only makes stimulus and reports the verdict.
// ============================================================================
`timescale 1ns / 1ps

module tb_text_stream_line_filter;
    import tslf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    // Cycles left after the last expected char before touching config or ending.
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BYTES   = 10;
    localparam int NUMBERED_RUN  = 120;

    typedef enum int {RX_ALWAYS, RX_PATTERN, RX_SPARSE, RX_COIN} rx_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_item;

    int mismatches;
    int chars_pending;
    int cycle_count = 0;
    int burst_left  = 0;

    always #2 clk = ~clk;

    text_stream_line_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    text_stream_line_filter_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item),
        .mismatches    (mismatches),
        .chars_pending (chars_pending)
    );

    // Watchdog: a hung handshake or missing chars ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL text_stream_line_filter");
            $finish;
        end
    end

    // Receiver: picks a new stall style whenever rx_step wraps. RX_ALWAYS gives
    // stretches with no backpressure, RX_SPARSE long stalls mid-number.
    rx_mode_t    rx_mode    = RX_ALWAYS;
    logic [15:0] rx_pattern = 16'hFFFF;
    int          rx_step    = 0;

    always @(negedge clk)
    begin
        if (rx_step == 0)
        begin
            rx_mode    = rx_mode_t'($urandom_range(RX_ALWAYS, RX_COIN));
            rx_pattern = 16'($urandom) | 16'h0001;
        end
        case (rx_mode)
            RX_ALWAYS:  out_ready <= 1'b1;
            RX_PATTERN: out_ready <= rx_pattern[rx_step % 16];
            RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
            default:    out_ready <= 1'($urandom_range(0, 1));
        endcase
        rx_step = (rx_step + 1) % 64;
    end

    // Writes every index the config port decodes, including unused ones,
    // with random filler in the bits above bit 0.
    task automatic write_mode(cfg_t m);
        logic [CFG_DATA_W-1:0] d;
        for (int r = 0; r < 2**CFG_INDEX_W; r++)
        begin
            d = CFG_DATA_W'($urandom);
            case (cfg_index_t'(r))
                CFG_NUMBER_ALL_LINES:     d[0] = m.number_all_lines;
                CFG_NUMBER_NONBLANK_ONLY: d[0] = m.number_nonblank_only;
                CFG_SQUEEZE_BLANK_RUNS:   d[0] = m.squeeze_blank_runs;
                CFG_MARK_LINE_ENDS:       d[0] = m.mark_line_ends;
                CFG_MARK_TABS:            d[0] = m.mark_tabs;
                CFG_SHOW_NONPRINTING:     d[0] = m.show_nonprinting;
                default: ;
            endcase
            cfg_index <= CFG_INDEX_W'(r);
            cfg_data  <= d;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // One byte request. Bursts of random length, separated by gaps so valid
    // never drops and rises in the same step.
    task automatic send_byte(logic [7:0] b, logic first);
        in_item_t req;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
        end
        req.in_byte       = b;
        req.first_of_file = first;
        in_item  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Drop valid, then let every expected char drain and the pipe settle.
    task automatic close_phase();
        in_valid <= 1'b0;
        burst_left = 0;
        while (chars_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Text-like bytes, heavy on newlines so blank runs and numbering occur,
    // with control, high and arbitrary bytes mixed in.
    function automatic logic [7:0] pick_text_byte();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 8'($urandom_range(CH_SPACE, {1'b0, CH_DEL7} - 1));
        else if (k < 62)
            return CH_NL;
        else if (k < 70)
            return CH_TAB;
        else if (k < 78)
            return 8'($urandom_range(0, CH_SPACE - 1));
        else if (k < 88)
            return 8'($urandom_range(128, 255));
        else if (k < 91)
            return {1'b0, CH_DEL7};
        return 8'($urandom);
    endfunction

    task automatic random_phase(cfg_t m);
        int sent;
        int run;
        write_mode(m);
        sent = 0;
        send_byte(pick_text_byte(), 1'($urandom_range(0, 1)));
        while (sent < PHASE_BYTES)
        begin
            // Sometimes a blank-line run to reach the squeeze path.
            if ($urandom_range(0, 7) == 0)
            begin
                run = $urandom_range(2, 5);
                repeat (run)
                    send_byte(CH_NL, 1'b0);
                sent += run;
            end
            else
            begin
                send_byte(pick_text_byte(), $urandom_range(0, 19) == 0);
                sent++;
            end
        end
        close_phase();
    endtask

    initial
    begin
        cfg_t m;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: all visible-form options on, numbering every line, and
        // no file start yet, so the first line carries no number. Covers
        // caret, DEL, the M- forms at both ends, and a squeezed newline.
        m = '0;
        m.number_all_lines   = 1'b1;
        m.squeeze_blank_runs = 1'b1;
        m.mark_line_ends     = 1'b1;
        m.mark_tabs          = 1'b1;
        m.show_nonprinting   = 1'b1;
        write_mode(m);
        send_byte("a", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte({1'b0, CH_DEL7}, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'h1F, 1'b0);
        close_phase();

        // Directed: non-blank numbering wins over all-lines; file start on
        // a newline prints no number, on text it does. Plain output mode.
        m = '0;
        m.number_all_lines     = 1'b1;
        m.number_nonblank_only = 1'b1;
        write_mode(m);
        send_byte(CH_NL, 1'b1);
        send_byte(CH_NL, 1'b0);
        send_byte("x", 1'b0);
        send_byte("y", 1'b1);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(8'hFF, 1'b0);
        close_phase();

        // Random phases: all off, all on, then random settings.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                m = '0;
            else if (p == 1)
                m = '1;
            else
                m = cfg_t'($bits(cfg_t)'($urandom));
            random_phase(m);
        end

        // Long numbered file so line numbers reach three digits.
        m = '0;
        m.number_all_lines = 1'b1;
        write_mode(m);
        send_byte("z", 1'b1);
        repeat (NUMBERED_RUN)
            send_byte(($urandom_range(0, 7) == 0) ? pick_text_byte() : CH_NL, 1'b0);
        close_phase();

        if (mismatches == 0)
            $display("PASS text_stream_line_filter");
        else
            $display("FAIL text_stream_line_filter");
        $finish;
    end

endmodule

// File: sim.f
hdl/tslf_pkg.sv
hdl/tslf_front.sv
hdl/tslf_queue.sv
hdl/tslf_back.sv
hdl/text_stream_line_filter.sv
tb/text_stream_line_filter_checker.sv
tb/tb_text_stream_line_filter.sv
